### hw/rtl/ethrx_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ethrx_pkg: shared types and constants for the receive address filter
// Address and CRC widths, item and configuration structs, class codes and
// the byte-wide CRC-32 update used by each CRC stage.
// ----------------------------------------------------------------------------
package ethrx_pkg;

    localparam int ADDR_W      = 48;
    localparam int CRC_W       = 32;
    localparam int HASH_W      = 6;
    localparam int TABLE_DEPTH = 64;
    localparam int NUM_BYTES   = ADDR_W / 8;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CRC_W-1:0] CRC_POLY   = 32'h04C1_1DB7;
    localparam logic [CRC_W-1:0] CRC_PRESET = 32'hFFFF_FFFF;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_STATION_ADDRESS  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HASH_TABLE       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PROMISCUOUS      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ACCEPT_BROADCAST = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ACCEPT_ALL_MCAST = 3'd4;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CRC_W-1:0]  crc_t;

    typedef enum logic [1:0] {
        CLASS_UNICAST   = 2'd0,
        CLASS_BROADCAST = 2'd1,
        CLASS_MULTICAST = 2'd2
    } frame_class_t;

    // item travelling down the CRC pipeline
    typedef struct packed {
        addr_t addr;
        crc_t  crc;
    } ethrx_item_t;

    // filter settings seen by the decision stage
    typedef struct packed {
        addr_t                  station_address;
        logic [TABLE_DEPTH-1:0] hash_table;
        logic                   promiscuous;
        logic                   accept_broadcast;
        logic                   accept_all_multicast;
    } ethrx_cfg_t;

    // CRC-32 over one byte, LSB first, no inversion
    function automatic crc_t crc_byte(input crc_t crc_in, input logic [7:0] data);
        crc_t c;
        logic fb;
        c = crc_in;
        for (int i = 0; i < 8; i++)
        begin
            fb = c[CRC_W-1] ^ data[i];
            c  = {c[CRC_W-2:0], 1'b0};
            if (fb)
            begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/ethrx_crc_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ethrx_crc_stage: one byte of the address CRC, registered
// Folds one address byte into the running CRC and holds the item until the
// next stage takes it.
// ----------------------------------------------------------------------------
module ethrx_crc_stage
    import ethrx_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output      logic        in_ready,
    input  wire ethrx_item_t in_item,
    input  wire logic [7:0]  in_byte,
    output      logic        out_valid,
    input  wire logic        out_ready,
    output      ethrx_item_t out_item
);

    logic        valid_reg;
    logic        valid_next;
    ethrx_item_t item_reg;
    ethrx_item_t item_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        item_next.addr = in_item.addr;
        item_next.crc  = crc_byte(in_item.crc, in_byte);
        valid_next     = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule
`default_nettype wire

### hw/rtl/ethrx_decide.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ethrx_decide: classification, hash lookup and accept decision
// Last pipeline stage; its registers are the block's output item.
// ----------------------------------------------------------------------------
module ethrx_decide
    import ethrx_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output      logic              in_ready,
    input  wire ethrx_item_t       in_item,
    input  wire ethrx_cfg_t        cfg,
    output      logic              out_valid,
    input  wire logic              out_ready,
    output      logic              accept,
    output      logic [1:0]        frame_class,
    output      logic [HASH_W-1:0] hash_index
);

    logic              valid_reg;
    logic              valid_next;
    logic              accept_reg;
    logic              accept_next;
    frame_class_t      class_reg;
    frame_class_t      class_next;
    logic [HASH_W-1:0] hash_reg;
    logic [HASH_W-1:0] hash_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        hash_next = in_item.crc[CRC_W-1 -: HASH_W];

        // group bit is bit 0 of the first byte
        priority if (!in_item.addr[0])
        begin
            class_next = CLASS_UNICAST;
        end
        else if (&in_item.addr)
        begin
            class_next = CLASS_BROADCAST;
        end
        else
        begin
            class_next = CLASS_MULTICAST;
        end

        priority if (cfg.promiscuous)
        begin
            accept_next = 1'b1;
        end
        else if (class_next == CLASS_UNICAST)
        begin
            accept_next = (in_item.addr == cfg.station_address);
        end
        else if (class_next == CLASS_BROADCAST)
        begin
            accept_next = cfg.accept_broadcast;
        end
        else if (cfg.accept_all_multicast)
        begin
            accept_next = 1'b1;
        end
        else
        begin
            accept_next = cfg.hash_table[hash_next];
        end

        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            accept_reg <= accept_next;
            class_reg  <= class_next;
            hash_reg   <= hash_next;
        end
    end

    assign out_valid   = valid_reg;
    assign accept      = accept_reg;
    assign frame_class = class_reg;
    assign hash_index  = hash_reg;

endmodule
`default_nettype wire

### hw/rtl/ethernet_rx_address_filter_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ethernet_rx_address_filter_unit: receive destination address filter
// Accepts or rejects a frame by its destination address: promiscuous mode,
// station address match, broadcast enable, all-multicast or CRC hash table.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid/in_ready with dest_address (first byte on the
//   wire at bits 7..0). Output channel: out_valid/out_ready with accept,
//   frame_class and hash_index, one result item per address item.
//   Config channel: cfg_valid/cfg_ready, cfg_index selects the register,
//   cfg_data carries its value; cfg_ready is always high, writes to
//   indexes past the last register are dropped. Write only while idle.
// Pipeline: from input acceptance to out_valid an item passes six CRC byte
//   stages, one per address byte, then the decision/output register.
// Throughput: one item per cycle while out_ready is high; the byte-wide CRC
//   step in each stage sets the stage depth.
// Reset: pipeline emptied, station address and hash table cleared,
//   promiscuous mode on, broadcast and all-multicast off.
// Stall: with out_ready low each full stage holds its item; in_ready drops
//   once the pipeline is full, and nothing is lost or repeated.
// ----------------------------------------------------------------------------
module ethernet_rx_address_filter_unit
    import ethrx_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // address items
    input  wire logic                   in_valid,
    output      logic                   in_ready,
    input  wire logic [ADDR_W-1:0]      dest_address,
    // result items
    output      logic                   out_valid,
    input  wire logic                   out_ready,
    output      logic                   accept,
    output      logic [1:0]             frame_class,
    output      logic [HASH_W-1:0]      hash_index,
    // register writes
    input  wire logic                   cfg_valid,
    output      logic                   cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    addr_t                  station_address_reg;
    addr_t                  station_address_next;
    logic [TABLE_DEPTH-1:0] hash_table_reg;
    logic [TABLE_DEPTH-1:0] hash_table_next;
    logic                   promiscuous_reg;
    logic                   promiscuous_next;
    logic                   accept_broadcast_reg;
    logic                   accept_broadcast_next;
    logic                   accept_all_mcast_reg;
    logic                   accept_all_mcast_next;
    ethrx_cfg_t             cfg;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        station_address_next  = station_address_reg;
        hash_table_next       = hash_table_reg;
        promiscuous_next      = promiscuous_reg;
        accept_broadcast_next = accept_broadcast_reg;
        accept_all_mcast_next = accept_all_mcast_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_STATION_ADDRESS:  station_address_next  = cfg_data[ADDR_W-1:0];
                REG_HASH_TABLE:       hash_table_next       = cfg_data[TABLE_DEPTH-1:0];
                REG_PROMISCUOUS:      promiscuous_next      = cfg_data[0];
                REG_ACCEPT_BROADCAST: accept_broadcast_next = cfg_data[0];
                REG_ACCEPT_ALL_MCAST: accept_all_mcast_next = cfg_data[0];
                default:              ; // unused index: write dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            station_address_reg  <= '0;
            hash_table_reg       <= '0;
            promiscuous_reg      <= 1'b1;
            accept_broadcast_reg <= 1'b0;
            accept_all_mcast_reg <= 1'b0;
        end
        else
        begin
            station_address_reg  <= station_address_next;
            hash_table_reg       <= hash_table_next;
            promiscuous_reg      <= promiscuous_next;
            accept_broadcast_reg <= accept_broadcast_next;
            accept_all_mcast_reg <= accept_all_mcast_next;
        end
    end

    assign cfg.station_address      = station_address_reg;
    assign cfg.hash_table           = hash_table_reg;
    assign cfg.promiscuous          = promiscuous_reg;
    assign cfg.accept_broadcast     = accept_broadcast_reg;
    assign cfg.accept_all_multicast = accept_all_mcast_reg;

    // ------------------------------------------------------------------
    // CRC pipeline: stage k folds address byte k into the CRC.
    // Slot 0 is the input port, slot NUM_BYTES feeds the decision stage.
    // ------------------------------------------------------------------
    ethrx_item_t slot_item  [NUM_BYTES+1];
    logic        slot_valid [NUM_BYTES+1];
    logic        slot_ready [NUM_BYTES+1];

    assign slot_item[0].addr = dest_address;
    assign slot_item[0].crc  = CRC_PRESET;
    assign slot_valid[0]     = in_valid;
    assign in_ready          = slot_ready[0];

    for (genvar k = 0; k < NUM_BYTES; k++)
    begin : g_crc
        ethrx_crc_stage u_crc_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (slot_valid[k]),
            .in_ready  (slot_ready[k]),
            .in_item   (slot_item[k]),
            .in_byte   (slot_item[k].addr[8*k +: 8]),
            .out_valid (slot_valid[k+1]),
            .out_ready (slot_ready[k+1]),
            .out_item  (slot_item[k+1])
        );
    end

    // ------------------------------------------------------------------
    // Decision stage and output register
    // ------------------------------------------------------------------
    ethrx_decide u_decide (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (slot_valid[NUM_BYTES]),
        .in_ready    (slot_ready[NUM_BYTES]),
        .in_item     (slot_item[NUM_BYTES]),
        .cfg         (cfg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .accept      (accept),
        .frame_class (frame_class),
        .hash_index  (hash_index)
    );

endmodule
`default_nettype wire
